### sv/tcg_pkg.sv
package tcg_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH        = 32;
    localparam int BYTES_PER_WORD     = 4;
    localparam int MAX_DONE_PER_GRANT = 32;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W = 16 + $clog2(BYTES_PER_WORD);
    localparam int DONE_W = $clog2(MAX_DONE_PER_GRANT + 1);

    // Configuration port
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_COUNT_LIMIT = 2'd0;
    localparam logic [1:0] REG_BYTE_LIMIT  = 2'd1;
    localparam logic [1:0] REG_LATENCY     = 2'd2;

    typedef enum logic [1:0] {
        OP_PUT     = 2'd0,
        OP_GRANT   = 2'd1,
        OP_RELEASE = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED      = 3'd0,
        ST_DROP_COUNT    = 3'd1,
        ST_DROP_BYTES    = 3'd2,
        ST_DONE          = 3'd3,
        ST_RELEASED      = 3'd4,
        ST_GRANT_END     = 3'd5,
        ST_RELEASE_EMPTY = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PUT,
        S_GRANT,
        S_RELEASE
    } state_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] packet_id;
        logic [15:0] packet_size;
        logic [15:0] grant_words;
    } tcg_item_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] out_packet_id;
        logic [15:0] out_packet_size;
        logic [31:0] release_delay;
        logic [15:0] remaining_bytes;
        logic        last;
    } tcg_result_t;

    typedef struct packed {
        logic [5:0]  count_limit;
        logic [21:0] byte_limit;
        logic [15:0] latency;
    } tcg_cfg_t;

    // Ring entry: size in the upper half, id in the lower
    typedef struct packed {
        logic [15:0] size;
        logic [15:0] id;
    } tcg_entry_t;

    typedef struct packed {
        logic [PTR_W-1:0] rd_addr;
        logic             we;
        logic [PTR_W-1:0] wr_addr;
        tcg_entry_t       wr_data;
    } tcg_ring_req_t;

    // Ring pointer step with wrap at the queue depth
    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr);
        logic [PTR_W:0] n;
        n = {1'b0, ptr} + (PTR_W+1)'(1);
        return (n >= (PTR_W+1)'(QUEUE_DEPTH)) ? '0 : n[PTR_W-1:0];
    endfunction

endpackage

### sv/tcg_ring.sv
module tcg_ring (
    input  logic                  clk,
    input  tcg_pkg::tcg_ring_req_t req,
    output tcg_pkg::tcg_entry_t   rd_data
);
    import tcg_pkg::*;

    tcg_entry_t mem [QUEUE_DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data <= mem[req.rd_addr];
    end

endmodule

### sv/tcg_seq.sv
module tcg_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tcg_pkg::tcg_cfg_t      cfg,
    input  logic                   start,
    input  tcg_pkg::tcg_item_t     item,
    output logic                   busy,
    output logic                   result_valid,
    output tcg_pkg::tcg_result_t   result,
    output tcg_pkg::tcg_ring_req_t ring_req,
    input  tcg_pkg::tcg_entry_t    ring_data
);
    import tcg_pkg::*;

    state_t            state_reg, state_next;
    tcg_item_t         item_reg, item_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [DONE_W-1:0] done_reg, done_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  gr_ptr_reg, gr_ptr_next;
    logic [PTR_W-1:0]  rel_ptr_reg, rel_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  done_cnt_reg, done_cnt_next;
    logic [21:0]       byte_total_reg, byte_total_next;
    logic              head_active_reg, head_active_next;
    logic [15:0]       needed_reg, needed_next;
    logic [15:0]       try_reg, try_next;
    logic              valid_reg, valid_next;
    tcg_result_t       result_reg, result_next;

    // Shared subtract/compare unit: grant bytes left against bytes needed
    logic [15:0]       need;
    logic [SLOT_W:0]   diff;
    logic [SLOT_W:0]   diff_neg;
    logic              fits;
    logic [CNT_W-1:0]  queued;
    logic [31:0]       delay;

    assign need     = head_active_reg ? needed_reg : ring_data.size;
    assign diff     = {1'b0, slot_reg} - (SLOT_W+1)'(need);
    assign diff_neg = '0 - diff;
    assign fits     = !diff[SLOT_W];
    assign queued   = count_reg - done_cnt_reg;
    assign delay    = 32'(cfg.latency) * 32'(try_reg);

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = valid_reg;
    assign result       = result_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            wr_ptr_reg      <= '0;
            gr_ptr_reg      <= '0;
            rel_ptr_reg     <= '0;
            count_reg       <= '0;
            done_cnt_reg    <= '0;
            byte_total_reg  <= '0;
            head_active_reg <= 1'b0;
            needed_reg      <= '0;
            try_reg         <= 16'd1;
            valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            wr_ptr_reg      <= wr_ptr_next;
            gr_ptr_reg      <= gr_ptr_next;
            rel_ptr_reg     <= rel_ptr_next;
            count_reg       <= count_next;
            done_cnt_reg    <= done_cnt_next;
            byte_total_reg  <= byte_total_next;
            head_active_reg <= head_active_next;
            needed_reg      <= needed_next;
            try_reg         <= try_next;
            valid_reg       <= valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        slot_reg   <= slot_next;
        done_reg   <= done_next;
        result_reg <= result_next;
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        item_next        = item_reg;
        slot_next        = slot_reg;
        done_next        = done_reg;
        wr_ptr_next      = wr_ptr_reg;
        gr_ptr_next      = gr_ptr_reg;
        rel_ptr_next     = rel_ptr_reg;
        count_next       = count_reg;
        done_cnt_next    = done_cnt_reg;
        byte_total_next  = byte_total_reg;
        head_active_next = head_active_reg;
        needed_next      = needed_reg;
        try_next         = try_reg;
        valid_next       = 1'b0;
        result_next      = '0;

        ring_req.rd_addr = gr_ptr_reg;
        ring_req.we      = 1'b0;
        ring_req.wr_addr = wr_ptr_reg;
        ring_req.wr_data = '{size: item_reg.packet_size, id: item_reg.packet_id};

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next = item;
                    slot_next = SLOT_W'(item.grant_words) * SLOT_W'(BYTES_PER_WORD);
                    done_next = '0;
                    unique case (item.op)
                        OP_PUT:     state_next = S_PUT;
                        OP_GRANT:   state_next = S_GRANT;
                        OP_RELEASE:
                        begin
                            ring_req.rd_addr = rel_ptr_reg;
                            state_next       = S_RELEASE;
                        end
                        default:    state_next = S_IDLE;
                    endcase
                end
            end

            // Limit checks, count before bytes
            S_PUT:
            begin
                valid_next                  = 1'b1;
                result_next.last            = 1'b1;
                result_next.out_packet_id   = item_reg.packet_id;
                result_next.out_packet_size = item_reg.packet_size;
                if ((cfg.count_limit != '0
                        && 7'(count_reg) >= 7'(cfg.count_limit))
                    || count_reg >= CNT_W'(QUEUE_DEPTH))
                begin
                    result_next.status = ST_DROP_COUNT;
                end
                else if (cfg.byte_limit != '0 && byte_total_reg >= cfg.byte_limit)
                begin
                    result_next.status = ST_DROP_BYTES;
                end
                else
                begin
                    result_next.status = ST_ACCEPTED;
                    ring_req.we        = 1'b1;
                    wr_ptr_next        = advance(wr_ptr_reg);
                    count_next         = count_reg + CNT_W'(1);
                    byte_total_next    = byte_total_reg + 22'(item_reg.packet_size);
                end
                state_next = S_IDLE;
            end

            // One head packet per cycle; ring_data holds the entry at gr_ptr
            S_GRANT:
            begin
                valid_next = 1'b1;
                if (!head_active_reg
                    && (queued == '0 || done_reg >= DONE_W'(MAX_DONE_PER_GRANT)))
                begin
                    if (queued == '0)
                    begin
                        needed_next = '0;
                    end
                    result_next.status = ST_GRANT_END;
                    result_next.last   = 1'b1;
                    state_next         = S_IDLE;
                end
                else if (fits)
                begin
                    result_next.status          = ST_DONE;
                    result_next.out_packet_id   = ring_data.id;
                    result_next.out_packet_size = ring_data.size;
                    result_next.release_delay   = delay;
                    done_next        = done_reg + DONE_W'(1);
                    slot_next        = diff[SLOT_W-1:0];
                    try_next         = 16'd1;
                    head_active_next = 1'b0;
                    gr_ptr_next      = advance(gr_ptr_reg);
                    ring_req.rd_addr = advance(gr_ptr_reg);
                    done_cnt_next    = done_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    head_active_next = 1'b1;
                    needed_next      = diff_neg[15:0];
                    if (try_reg != 16'hFFFF)
                    begin
                        try_next = try_reg + 16'd1;
                    end
                    result_next.status          = ST_GRANT_END;
                    result_next.out_packet_id   = ring_data.id;
                    result_next.out_packet_size = ring_data.size;
                    result_next.remaining_bytes = diff_neg[15:0];
                    result_next.last            = 1'b1;
                    state_next                  = S_IDLE;
                end
            end

            // ring_data holds the entry at rel_ptr
            S_RELEASE:
            begin
                valid_next       = 1'b1;
                result_next.last = 1'b1;
                if (done_cnt_reg == '0)
                begin
                    result_next.status = ST_RELEASE_EMPTY;
                end
                else
                begin
                    result_next.status          = ST_RELEASED;
                    result_next.out_packet_id   = ring_data.id;
                    result_next.out_packet_size = ring_data.size;
                    rel_ptr_next    = advance(rel_ptr_reg);
                    done_cnt_next   = done_cnt_reg - CNT_W'(1);
                    count_next      = count_reg - CNT_W'(1);
                    byte_total_next = byte_total_reg - 22'(ring_data.size);
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### sv/tcont_grant_queue.sv
// Upstream traffic-container queue with word grants.
// Commands enter on start/item and are taken when busy is low; op 0 puts a
// packet (tail drop on count or byte limit), op 1 grants a number of 32-bit
// words to the queued packets in order, op 2 releases the oldest completed
// packet. Op 3 is taken and ignored.
// Results leave on result with result_valid high for one cycle each; the
// last result of a command has result.last set. The receiver cannot stall.
// The first result is worked out in the command state entered at the accepting
// edge and is shown from the result register. Put and release give one result.
// A grant completes at most 32 packets, each with one subtract/compare step
// of the shared unit and one ring read, and ends with a grant-end result.
// busy drops in the cycle the last result is shown, so the next command
// may be taken at the edge that ends that cycle.
// Registers (APB, 32-bit, pready always high): 0x0 count_limit,
// 0x4 byte_limit, 0x8 latency. Write them only while busy is low.
// Reset clears pointers, counters and registers, sets the try count to one;
// the packet ring itself is not cleared and needs no clearing pass.
module tcont_grant_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  tcg_pkg::tcg_item_t         item,
    output logic                       busy,
    output logic                       result_valid,
    output tcg_pkg::tcg_result_t       result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tcg_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import tcg_pkg::*;

    logic [5:0]    count_limit_reg;
    logic [21:0]   byte_limit_reg;
    logic [15:0]   latency_reg;
    logic          cfg_wr;
    tcg_cfg_t      cfg;
    tcg_ring_req_t ring_req;
    tcg_entry_t    ring_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign cfg    = '{count_limit: count_limit_reg,
                      byte_limit:  byte_limit_reg,
                      latency:     latency_reg};

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_limit_reg <= '0;
            byte_limit_reg  <= '0;
            latency_reg     <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_COUNT_LIMIT: count_limit_reg <= pwdata[5:0];
                REG_BYTE_LIMIT:  byte_limit_reg  <= pwdata[21:0];
                REG_LATENCY:     latency_reg     <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        unique case (paddr[3:2])
            REG_COUNT_LIMIT: prdata = 32'(count_limit_reg);
            REG_BYTE_LIMIT:  prdata = 32'(byte_limit_reg);
            REG_LATENCY:     prdata = 32'(latency_reg);
            default:         prdata = '0;
        endcase
    end

    tcg_ring u_ring (
        .clk     (clk),
        .req     (ring_req),
        .rd_data (ring_data)
    );

    tcg_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .ring_req     (ring_req),
        .ring_data    (ring_data)
    );

    // A command finishes with its last result in the cycle busy drops
    a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid && result.last)
        else $error("busy dropped without a last result");

    // Results of one grant follow back to back until the last
    a_burst_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |=> result_valid)
        else $error("gap inside a grant's result burst");

    // A completed packet is never the last result: a grant end always comes after it
    a_done_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_DONE |-> !result.last)
        else $error("packet done marked as last result");

endmodule

### tb/sv/tcg_checker.sv
module tcg_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  tcg_pkg::tcg_item_t         item,
    input  logic                       result_valid,
    input  tcg_pkg::tcg_result_t       result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [tcg_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output int                         error_count,
    output int                         results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tcg_pkg::*;

    // Shadow of the queue state
    tcg_cfg_t          cfg;
    tcg_entry_t        ring [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr;
    logic [PTR_W-1:0]  grant_ptr;
    logic [PTR_W-1:0]  rel_ptr;
    logic [5:0]        held;
    logic [5:0]        completed;
    logic [21:0]       bytes_held;
    logic              head_open;
    logic [15:0]       head_left;
    logic [15:0]       tries;

    // Results still owed by the block, oldest first
    tcg_result_t       outcomes_due [$];

    function automatic void owe(input status_t st, input logic [15:0] id,
                                input logic [15:0] size, input logic [31:0] delay,
                                input logic [15:0] left);
        tcg_result_t r;
        r.status          = st;
        r.out_packet_id   = id;
        r.out_packet_size = size;
        r.release_delay   = delay;
        r.remaining_bytes = left;
        r.last            = 1'b0;
        outcomes_due.push_back(r);
    endfunction

    // Work out the results of one command and move the shadow state on
    task automatic derive_outcomes(input tcg_item_t it);
        int          base;
        int          finished;
        logic [17:0] grant_bytes;
        tcg_entry_t  head;
        tcg_result_t tail;
        base = outcomes_due.size();
        case (it.op)
            OP_PUT:
            begin
                // count limit wins over the byte limit
                if ((cfg.count_limit != 0 && held >= cfg.count_limit) || held >= QUEUE_DEPTH)
                    owe(ST_DROP_COUNT, it.packet_id, it.packet_size, '0, '0);
                else if (cfg.byte_limit != 0 && bytes_held >= cfg.byte_limit)
                    owe(ST_DROP_BYTES, it.packet_id, it.packet_size, '0, '0);
                else
                begin
                    ring[wr_ptr].id   = it.packet_id;
                    ring[wr_ptr].size = it.packet_size;
                    wr_ptr     = wr_ptr + 1'b1;
                    held       = held + 1'b1;
                    bytes_held = bytes_held + 22'(it.packet_size);
                    owe(ST_ACCEPTED, it.packet_id, it.packet_size, '0, '0);
                end
            end
            OP_GRANT:
            begin
                grant_bytes = 18'(it.grant_words) * 18'(BYTES_PER_WORD);
                finished    = 0;
                forever
                begin
                    if (!head_open)
                    begin
                        if (held == completed || finished >= MAX_DONE_PER_GRANT)
                        begin
                            if (held == completed)
                                head_left = '0;
                            owe(ST_GRANT_END, '0, '0, '0, '0);
                            break;
                        end
                        head_open = 1'b1;
                        head_left = ring[grant_ptr].size;
                    end
                    head = ring[grant_ptr];
                    if (18'(head_left) <= grant_bytes)
                    begin
                        owe(ST_DONE, head.id, head.size, 32'(cfg.latency) * 32'(tries), '0);
                        finished++;
                        grant_bytes = grant_bytes - 18'(head_left);
                        tries       = 16'd1;
                        head_open   = 1'b0;
                        grant_ptr   = grant_ptr + 1'b1;
                        completed   = completed + 1'b1;
                    end
                    else
                    begin
                        // short grant: carry the shortfall, count another try
                        head_left = head_left - 16'(grant_bytes);
                        if (tries != 16'hFFFF)
                            tries = tries + 1'b1;
                        owe(ST_GRANT_END, head.id, head.size, '0, head_left);
                        break;
                    end
                end
            end
            OP_RELEASE:
            begin
                if (completed == 0)
                    owe(ST_RELEASE_EMPTY, '0, '0, '0, '0);
                else
                begin
                    head       = ring[rel_ptr];
                    rel_ptr    = rel_ptr + 1'b1;
                    completed  = completed - 1'b1;
                    held       = held - 1'b1;
                    bytes_held = bytes_held - 22'(head.size);
                    owe(ST_RELEASED, head.id, head.size, '0, '0);
                end
            end
            default: ;
        endcase
        if (outcomes_due.size() > base)
        begin
            tail      = outcomes_due.pop_back();
            tail.last = 1'b1;
            outcomes_due.push_back(tail);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            error_count++;
            if (error_count <= 100)
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    // Sample both channels and the register port at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        tcg_result_t want;
        if (!rst_n)
        begin
            cfg         = '0;
            wr_ptr      = '0;
            grant_ptr   = '0;
            rel_ptr     = '0;
            held        = '0;
            completed   = '0;
            bytes_held  = '0;
            head_open   = 1'b0;
            head_left   = '0;
            tries       = 16'd1;
            error_count = 0;
            outcomes_due.delete();
        end
        else
        begin
            // result transfer
            if (result_valid)
            begin
                if (outcomes_due.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 100)
                        $error("result with nothing due: status %0d id 0x%0h",
                               result.status, result.out_packet_id);
                end
                else
                begin
                    want = outcomes_due.pop_front();
                    check_field("status", 32'(want.status), 32'(result.status));
                    check_field("out_packet_id", 32'(want.out_packet_id),
                                32'(result.out_packet_id));
                    check_field("out_packet_size", 32'(want.out_packet_size),
                                32'(result.out_packet_size));
                    check_field("release_delay", want.release_delay, result.release_delay);
                    check_field("remaining_bytes", 32'(want.remaining_bytes),
                                32'(result.remaining_bytes));
                    check_field("last", 32'(want.last), 32'(result.last));
                end
            end
            // register write
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_COUNT_LIMIT: cfg.count_limit = pwdata[5:0];
                    REG_BYTE_LIMIT:  cfg.byte_limit  = pwdata[21:0];
                    REG_LATENCY:     cfg.latency     = pwdata[15:0];
                    default: ;
                endcase
            end
            // command transfer
            if (start && !busy)
                derive_outcomes(item);
        end
        results_pending = outcomes_due.size();
    end

endmodule

### tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcg_pkg::*;

    // op code the block takes and ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic              clk;
    logic              rst_n;
    logic              start;
    tcg_item_t         item;
    logic              busy;
    logic              result_valid;
    tcg_result_t       result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    int                error_count;
    int                results_pending;
    bit                gaps_on;

    tcont_grant_queue dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    tcg_checker u_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .item            (item),
        .result_valid    (result_valid),
        .result          (result),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .error_count     (error_count),
        .results_pending (results_pending)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic tcg_item_t command(input logic [1:0] code, input logic [15:0] id,
                                          input logic [15:0] size, input logic [15:0] words);
        tcg_item_t it;
        it.op          = op_t'(code);
        it.packet_id   = id;
        it.packet_size = size;
        it.grant_words = words;
        return it;
    endfunction

    // Mostly sensible traffic with random content, a little noise
    function automatic tcg_item_t random_command();
        int        pick;
        int        shape;
        tcg_item_t it;
        pick  = $urandom_range(99);
        shape = $urandom_range(99);
        it    = command(OP_PUT, 16'($urandom), 16'($urandom), 16'($urandom));
        if (pick < 40)
        begin
            if (shape < 80)
                it.packet_size = 16'($urandom_range(300, 1));
            else if (shape < 95)
                it.packet_size = 16'($urandom_range(65535, 1));
            else
                it.packet_size = '0;
        end
        else if (pick < 72)
        begin
            it.op = OP_GRANT;
            if (shape < 70)
                it.grant_words = 16'($urandom_range(100));
            else if (shape < 90)
                it.grant_words = 16'($urandom_range(2000));
        end
        else if (pick < 95)
            it.op = OP_RELEASE;
        else
            it.op = op_t'(OP_UNUSED);
        return it;
    endfunction

    // One command transfer, with an occasional idle burst ahead of it
    task automatic issue(input tcg_item_t it);
        int gap;
        if (gaps_on && $urandom_range(3) == 0)
        begin
            gap = $urandom_range(10, 1);
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start = 1'b1;
        item  = it;
        do @(posedge clk); while (busy);
    endtask

    // Wait until every owed result is in and the block is idle
    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        while (results_pending != 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {index, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_config(input logic [5:0] count_limit, input logic [21:0] byte_limit,
                              input logic [15:0] latency);
        settle();
        write_reg(REG_COUNT_LIMIT, 32'(count_limit));
        write_reg(REG_BYTE_LIMIT, 32'(byte_limit));
        write_reg(REG_LATENCY, 32'(latency));
    endtask

    // Hard stop if the block hangs
    initial
    begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n   = 1'b0;
        start   = 1'b0;
        item    = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        gaps_on = 1'b1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // count limit of two, empty queue cases, carry-over across grants
        set_config(6'd2, 22'd0, 16'd7);
        issue(command(OP_RELEASE, 16'h1111, 16'h2222, 16'h3333));
        issue(command(OP_GRANT, 16'h4444, 16'h5555, 16'd5));
        issue(command(OP_PUT, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        issue(command(OP_PUT, 16'h0000, 16'd1, 16'h0000));
        issue(command(OP_PUT, 16'h1234, 16'd10, 16'h0000));
        issue(command(OP_GRANT, 16'h0000, 16'h0000, 16'd0));
        issue(command(OP_GRANT, 16'h0000, 16'h0000, 16'd16383));
        issue(command(OP_GRANT, 16'h0000, 16'h0000, 16'd1));
        repeat (3) issue(command(OP_RELEASE, 16'h0000, 16'h0000, 16'h0000));
        issue(command(OP_UNUSED, 16'hBEEF, 16'hCAFE, 16'h0F0F));

        // byte limit of one, zero-size packet completed by a zero grant
        set_config(6'd0, 22'd1, 16'hFFFF);
        issue(command(OP_PUT, 16'hA5A5, 16'd0, 16'h0000));
        issue(command(OP_PUT, 16'h5A5A, 16'd5, 16'h0000));
        issue(command(OP_PUT, 16'h0F0F, 16'd9, 16'h0000));
        issue(command(OP_GRANT, 16'h0000, 16'h0000, 16'd0));

        // both limits reached: count drop expected
        set_config(6'd1, 22'd1, 16'hFFFF);
        issue(command(OP_PUT, 16'h7777, 16'd3, 16'h0000));
        issue(command(OP_GRANT, 16'h0000, 16'h0000, 16'd2));
        repeat (2) issue(command(OP_RELEASE, 16'h0000, 16'h0000, 16'h0000));

        // full queue, one grant finishing all 32 packets, drain
        set_config(6'd32, 22'h3FFFFF, 16'd100);
        repeat (QUEUE_DEPTH)
            issue(command(OP_PUT, 16'($urandom), 16'($urandom_range(8, 1)), 16'($urandom)));
        issue(command(OP_PUT, 16'hDEAD, 16'd4, 16'h0000));
        issue(command(OP_GRANT, 16'h0000, 16'h0000, 16'hFFFF));
        repeat (QUEUE_DEPTH)
            issue(command(OP_RELEASE, 16'($urandom), 16'($urandom), 16'($urandom)));

        // repeated zero grants raise the try count, largest latency
        set_config(6'd0, 22'd0, 16'hFFFF);
        gaps_on = 1'b0;
        issue(command(OP_PUT, 16'h8001, 16'hFFFF, 16'h0000));
        repeat (20)
            issue(command(OP_GRANT, 16'($urandom), 16'($urandom), 16'd0));
        issue(command(OP_GRANT, 16'h0000, 16'h0000, 16'd16384));
        issue(command(OP_RELEASE, 16'h0000, 16'h0000, 16'h0000));
        gaps_on = 1'b1;

        // random traffic under several register settings
        set_config(6'd0, 22'd0, 16'($urandom_range(65535)));
        repeat (75) issue(random_command());
        set_config(6'd32, 22'h3FFFFF, 16'hFFFF);
        repeat (75) issue(random_command());
        set_config(6'($urandom_range(31, 1)), 22'($urandom_range(5000, 200)),
                   16'($urandom_range(200)));
        repeat (75) issue(random_command());
        set_config(6'd0, 22'($urandom_range(3000, 500)), 16'd0);
        gaps_on = 1'b0;
        repeat (75) issue(random_command());

        settle();
        repeat (20) @(negedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
